// ===== rtl/mbss_pkg.sv =====
// Shared types and constants of the masked byte signature scanner.
`default_nettype none
package mbss_pkg;
	localparam int unsigned MaxBytes  = 32;
	localparam int unsigned LenWidth  = 6;
	localparam int unsigned OffWidth  = 32;
	localparam int unsigned CfgWidth  = 64;
	localparam int unsigned IdxWidth  = 3;
	localparam int unsigned ShWidth   = $clog2(MaxBytes);

	localparam logic [IdxWidth-1:0] RegPatLo    = 3'd0;
	localparam logic [IdxWidth-1:0] RegPatMidLo = 3'd1;
	localparam logic [IdxWidth-1:0] RegPatMidHi = 3'd2;
	localparam logic [IdxWidth-1:0] RegPatHi    = 3'd3;
	localparam logic [IdxWidth-1:0] RegMask     = 3'd4;
	localparam logic [IdxWidth-1:0] RegLength   = 3'd5;
	localparam logic [IdxWidth-1:0] RegReportAll = 3'd6;

	typedef logic [MaxBytes-1:0][7:0] window_t;

	typedef struct packed {
		logic                hit;
		logic [OffWidth-1:0] start_offset;
		logic                scan_done;
	} result_t;
endpackage
`default_nettype wire

// ===== rtl/mbss_match.sv =====
// Window compare: aligns the masked signature to the window and checks every byte at once.
`default_nettype none
module mbss_match (
	input  wire mbss_pkg::window_t              window,
	input  wire mbss_pkg::window_t              pattern,
	input  wire [mbss_pkg::MaxBytes-1:0]        mask,
	input  wire [mbss_pkg::LenWidth-1:0]        length,
	output logic                                match
);
	mbss_pkg::window_t                 pat_rev;
	mbss_pkg::window_t                 pat_aligned;
	logic [mbss_pkg::MaxBytes-1:0]     mask_rev;
	logic [mbss_pkg::MaxBytes-1:0]     mask_aligned;
	logic [mbss_pkg::ShWidth-1:0]      shift;
	logic [mbss_pkg::MaxBytes-1:0]     byte_ok;

	// window[0] is the newest byte; it must equal signature byte length-1
	always_comb begin
		for (int j = 0; j < mbss_pkg::MaxBytes; j++) begin
			pat_rev[j]  = pattern[mbss_pkg::MaxBytes-1-j];
			mask_rev[j] = mask[mbss_pkg::MaxBytes-1-j];
		end
		shift        = mbss_pkg::ShWidth'(mbss_pkg::LenWidth'(mbss_pkg::MaxBytes) - length);
		pat_aligned  = pat_rev >> {shift, 3'b000};
		// positions at or beyond length shift in as zero, so they act as wildcards
		mask_aligned = mask_rev >> shift;
		for (int j = 0; j < mbss_pkg::MaxBytes; j++) begin
			byte_ok[j] = !mask_aligned[j] || (window[j] == pat_aligned[j]);
		end
		match = &byte_ok;
	end
endmodule
`default_nettype wire

// ===== rtl/masked_byte_signature_scan_core.sv =====
// A result is registered in the output register, or the skid entry if m_tready is low.
// Throughput: one byte per cycle while s_tready is high; window shift and all 32 byte
// compares end in the accept cycle; a two-entry output register absorbs output stalls.
// Reset (arst_n low): signature bytes 0, compare mask all ones, length 1, first-only
// mode, window, byte count and reported flag cleared, no result pending.
`default_nettype none
module masked_byte_signature_scan_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,  // data_byte[7:0]
	input  wire                               s_tlast,  // last_byte
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [mbss_pkg::OffWidth-1:0]     m_tdata,  // start_offset[31:0]
	output logic                              m_tuser,  // hit
	output logic                              m_tlast,  // scan_done
	input  wire                               cfg_we,
	input  wire  [mbss_pkg::IdxWidth-1:0]     cfg_index,
	input  wire  [mbss_pkg::CfgWidth-1:0]     cfg_wdata
);
	mbss_pkg::window_t                  pattern_q;
	logic [mbss_pkg::MaxBytes-1:0]      mask_q;
	logic [mbss_pkg::LenWidth-1:0]      length_q;
	logic                               report_all_q;

	mbss_pkg::window_t                  window_q;
	mbss_pkg::window_t                  window_next;
	logic [mbss_pkg::OffWidth-1:0]      seen_q;
	logic                               reported_q;

	logic [mbss_pkg::LenWidth-1:0]      len_used;
	logic [mbss_pkg::OffWidth:0]        count_incl;
	logic                               match;
	logic                               hit_c;
	logic                               accept;
	logic                               res_valid;
	mbss_pkg::result_t                  res;

	mbss_pkg::result_t                  out_q;
	logic                               out_valid_q;
	mbss_pkg::result_t                  skid_q;
	logic                               skid_valid_q;
	logic                               out_adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= '0;
			mask_q       <= '1;
			length_q     <= mbss_pkg::LenWidth'(1);
			report_all_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbss_pkg::RegPatLo:     pattern_q[7:0]   <= cfg_wdata;
				mbss_pkg::RegPatMidLo:  pattern_q[15:8]  <= cfg_wdata;
				mbss_pkg::RegPatMidHi:  pattern_q[23:16] <= cfg_wdata;
				mbss_pkg::RegPatHi:     pattern_q[31:24] <= cfg_wdata;
				mbss_pkg::RegMask:      mask_q       <= cfg_wdata[mbss_pkg::MaxBytes-1:0];
				mbss_pkg::RegLength:    length_q     <= cfg_wdata[mbss_pkg::LenWidth-1:0];
				mbss_pkg::RegReportAll: report_all_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (length_q == '0)
			len_used = mbss_pkg::LenWidth'(1);
		else if (length_q > mbss_pkg::LenWidth'(mbss_pkg::MaxBytes))
			len_used = mbss_pkg::LenWidth'(mbss_pkg::MaxBytes);
		else
			len_used = length_q;
	end

	assign window_next = {window_q[mbss_pkg::MaxBytes-2:0], s_tdata};
	assign count_incl  = {1'b0, seen_q} + (mbss_pkg::OffWidth+1)'(1);

	mbss_match u_match (
		.window  (window_next),
		.pattern (pattern_q),
		.mask    (mask_q),
		.length  (len_used),
		.match   (match)
	);

	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign hit_c     = (count_incl >= (mbss_pkg::OffWidth+1)'(len_used)) && match
		&& (report_all_q || !reported_q);
	assign res_valid = accept && (hit_c || s_tlast);

	always_comb begin
		res.hit          = hit_c;
		res.start_offset = hit_c
			? mbss_pkg::OffWidth'(count_incl - (mbss_pkg::OffWidth+1)'(len_used))
			: '0;
		res.scan_done    = s_tlast;
	end

	// scan state: drop everything at the end of a scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				window_q   <= '0;
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				window_q   <= window_next;
				seen_q     <= count_incl[mbss_pkg::OffWidth-1:0];
				reported_q <= reported_q || hit_c;
			end
		end
	end

	// output register with skid entry
	assign out_adv = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_adv) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.start_offset;
	assign m_tuser  = out_q.hit;
	assign m_tlast  = out_q.scan_done;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_nohit_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
		else $error("result without hit must be a done result with zero offset");

	a_scan_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (seen_q == '0 && !reported_q))
		else $error("scan state not cleared after last byte");

	a_first_only: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hit_c && !report_all_q) |-> !reported_q)
		else $error("second hit reported in first-only mode");
endmodule
`default_nettype wire
